// ----- hw/rtl/aes_block_cipher_unit_defines.svh -----
// assertion macros for the aes block cipher unit
`ifndef AES_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define AES_BLOCK_CIPHER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on the rising clock edge outside reset
`define AES_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define AES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AES_ASSERT_IMPL(label, ante, cons, msg)
`define AES_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/aes_pkg.sv -----
// shared types, constants and round functions of the aes block cipher unit
`default_nettype none
package aes_pkg;
	localparam int NbCols = 4;
	localparam int RoundExtra = 6;
	localparam int RowCount = 15;
	localparam int RowAddrW = $clog2(RowCount);

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_KEY_SIZE = 3'd4;
	localparam logic [2:0] REG_MODE = 3'd5;

	localparam logic [1:0] KEY_SIZE_128 = 2'd0;
	localparam logic [1:0] KEY_SIZE_192 = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_KEYRD,
		ST_ROUND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic en;
		logic [RowAddrW-1:0] addr;
		logic [127:0] data;
	} ram_wr_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// byte n of the block sits in bits 127-8n downward; byte index is row + 4*column
	function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		o = '0;
		for (int n = 0; n < 16; n++) begin
			o[127-8*n -: 8] = inv ? INV_SBOX[s[127-8*n -: 8]] : SBOX[s[127-8*n -: 8]];
		end
		return o;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		o = s;
		for (int r = 1; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inv) begin
					o[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
				end else begin
					o[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
				end
			end
		end
		return o;
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
		logic [7:0] b [4];
		logic [7:0] m1 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m4 [4];
		logic [7:0] m8 [4];
		logic [31:0] o;
		for (int k = 0; k < 4; k++) begin
			b[k] = col[31-8*k -: 8];
			m2[k] = xtime(b[k]);
			m4[k] = xtime(m2[k]);
			m8[k] = xtime(m4[k]);
			m1[k] = b[k];
			m3[k] = m2[k] ^ b[k];
		end
		o = '0;
		for (int r = 0; r < 4; r++) begin
			if (inv) begin
				// 14, 11, 13, 9 around the column
				o[31-8*r -: 8] = (m8[r] ^ m4[r] ^ m2[r])
					^ (m8[(r+1)%4] ^ m2[(r+1)%4] ^ m1[(r+1)%4])
					^ (m8[(r+2)%4] ^ m4[(r+2)%4] ^ m1[(r+2)%4])
					^ (m8[(r+3)%4] ^ m1[(r+3)%4]);
			end else begin
				o[31-8*r -: 8] = m2[r] ^ m3[(r+1)%4] ^ m1[(r+2)%4] ^ m1[(r+3)%4];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			o[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
		end
		return o;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/aes_ram.sv -----
// generic single-write, registered-read ram
`default_nettype none
module aes_ram #(
	parameter int Width = 128,
	parameter int Depth = 15
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/aes_key_sched.sv -----
// key expansion sequencer, one schedule word per cycle, one row written per four words
`default_nettype none
module aes_key_sched import aes_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [255:0] key,
	input wire logic [1:0] key_size,
	output logic done,
	output ram_wr_t wr
);
	logic run_q;
	logic [5:0] i_q;
	logic [2:0] kmod_q;
	logic [7:0] rcon_q;
	logic [31:0] win_q [8];
	logic [95:0] row_q;

	logic [3:0] nk;
	logic [5:0] total;
	logic [31:0] back_nk;
	logic [31:0] t;
	logic [31:0] new_word;
	logic from_key;

	always_comb begin
		case (key_size)
			KEY_SIZE_128: nk = 4'd4;
			KEY_SIZE_192: nk = 4'd6;
			default: nk = 4'd8;
		endcase
		total = 6'(NbCols * (32'(nk) + RoundExtra + 1));
		case (key_size)
			KEY_SIZE_128: back_nk = win_q[3];
			KEY_SIZE_192: back_nk = win_q[5];
			default: back_nk = win_q[7];
		endcase
		from_key = i_q < {2'b00, nk};
		t = win_q[0];
		if (kmod_q == 3'd0) begin
			t = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && kmod_q == 3'd4) begin
			t = sub_word(win_q[0]);
		end
		new_word = from_key ? key[255 - 32*i_q[2:0] -: 32] : (back_nk ^ t);
		done = run_q && (i_q == total - 6'd1);
		wr.en = run_q && (i_q[1:0] == 2'd3);
		wr.addr = i_q[5:2];
		wr.data = {row_q, new_word};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q <= '0;
			kmod_q <= '0;
			rcon_q <= 8'h01;
		end else if (start) begin
			run_q <= 1'b1;
			i_q <= '0;
			kmod_q <= '0;
			rcon_q <= 8'h01;
		end else if (run_q) begin
			i_q <= i_q + 6'd1;
			kmod_q <= (kmod_q == 3'(nk - 4'd1)) ? 3'd0 : kmod_q + 3'd1;
			if (!from_key && kmod_q == 3'd0) begin
				rcon_q <= xtime(rcon_q);
			end
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			win_q[0] <= new_word;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
			row_q <= {row_q[63:0], new_word};
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/aes_round.sv -----
// one cipher or inverse-cipher round, shared across all rounds of a block
`default_nettype none
module aes_round import aes_pkg::*; (
	input wire logic [127:0] state,
	input wire logic [127:0] round_key,
	input wire logic inv,
	input wire logic first,
	input wire logic last,
	output logic [127:0] next_state
);
	logic [127:0] fwd_t;
	logic [127:0] inv_t;

	always_comb begin
		fwd_t = shift_rows(sub_bytes(state, 1'b0), 1'b0);
		inv_t = sub_bytes(shift_rows(state, 1'b1), 1'b1) ^ round_key;
		if (first) begin
			next_state = state ^ round_key;
		end else if (!inv) begin
			next_state = (last ? fwd_t : mix_columns(fwd_t, 1'b0)) ^ round_key;
		end else begin
			next_state = last ? inv_t : mix_columns(inv_t, 1'b1);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/aes_block_cipher_unit.sv -----
// top level of the aes block cipher unit
// AES-128/192/256 block cipher, one 128-bit block per beat, forward or inverse
// cipher as set by the mode register. The key schedule is expanded once after
// any key or key-size write, by the first block that follows, at one schedule
// word per cycle. A block then fetches its first round key, runs the shared
// round unit for the initial key addition and each of its 10, 12 or 14 rounds,
// and is handed to the output register.
// The input is stalled while a block is at work and opens again the cycle after
// the hand-off, so a new block is taken in only once the last one is handed off.
// A finished result waits in the output register while the next block is taken
// in; if that register is still held by out_stall when the next block finishes,
// the block waits in the hand-off step and the input stays stalled for as long.
// Round keys live in a 15-row by 128-bit ram, one row per round key.
`default_nettype none
`include "aes_block_cipher_unit_defines.svh"
module aes_block_cipher_unit import aes_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [5:0] paddr,
	input wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [63:0] block_high,
	input wire logic [63:0] block_low,
	output logic out_valid,
	input wire logic out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	// configuration registers
	logic [63:0] key0_q, key1_q, key2_q, key3_q;
	logic [1:0] key_size_q;
	logic decrypt_q;
	logic sched_ready_q;

	state_t state_q, state_d;
	logic [3:0] step_q;
	logic [127:0] data_q;
	logic out_valid_q;
	logic [127:0] result_q;

	logic cfg_wr;
	logic in_beat;
	logic [3:0] nr;
	logic [3:0] step_rd;
	logic [RowAddrW-1:0] raddr;
	logic [127:0] round_key;
	logic [127:0] round_out;
	logic first_step, last_step;
	logic exp_start, exp_done;
	logic out_load;
	ram_wr_t key_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_beat = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign result_high = result_q[127:64];
	assign result_low = result_q[63:0];

	always_comb begin
		case (paddr[5:3])
			REG_KEY0: prdata = key0_q;
			REG_KEY1: prdata = key1_q;
			REG_KEY2: prdata = key2_q;
			REG_KEY3: prdata = key3_q;
			REG_KEY_SIZE: prdata = {62'h0, key_size_q};
			REG_MODE: prdata = {63'h0, decrypt_q};
			default: prdata = '0;
		endcase
	end

	// rounds follow the key length; size three runs as a 256-bit key
	always_comb begin
		case (key_size_q)
			KEY_SIZE_128: nr = 4'd10;
			KEY_SIZE_192: nr = 4'd12;
			default: nr = 4'd14;
		endcase
	end

	// round key for the next step is read from the registered ram in the cycle before that step
	always_comb begin
		first_step = (step_q == 4'd0);
		last_step = (step_q == nr);
		step_rd = (state_q == ST_ROUND && !last_step) ? step_q + 4'd1 : 4'd0;
		raddr = decrypt_q ? RowAddrW'(nr - step_rd) : RowAddrW'(step_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
			key_size_q <= '0;
			decrypt_q <= 1'b0;
			sched_ready_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[5:3])
					REG_KEY0: begin
						key0_q <= pwdata;
						sched_ready_q <= 1'b0;
					end
					REG_KEY1: begin
						key1_q <= pwdata;
						sched_ready_q <= 1'b0;
					end
					REG_KEY2: begin
						key2_q <= pwdata;
						sched_ready_q <= 1'b0;
					end
					REG_KEY3: begin
						key3_q <= pwdata;
						sched_ready_q <= 1'b0;
					end
					REG_KEY_SIZE: begin
						key_size_q <= pwdata[1:0];
						sched_ready_q <= 1'b0;
					end
					REG_MODE: decrypt_q <= pwdata[0];
					default: ;
				endcase
			end else if (exp_done) begin
				sched_ready_q <= 1'b1;
			end
		end
	end

	// sequencer: expand if needed, fetch first key, run rounds, hand off result
	always_comb begin
		state_d = state_q;
		exp_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					exp_start = !sched_ready_q;
					state_d = sched_ready_q ? ST_KEYRD : ST_EXPAND;
				end
			end
			ST_EXPAND: if (exp_done) state_d = ST_KEYRD;
			ST_KEYRD: state_d = ST_ROUND;
			ST_ROUND: if (last_step) state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_KEYRD) begin
				step_q <= '0;
			end else if (state_q == ST_ROUND) begin
				step_q <= step_q + 4'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			data_q <= {block_high, block_low};
		end else if (state_q == ST_ROUND) begin
			data_q <= round_out;
		end
		if (out_load) begin
			result_q <= data_q;
		end
	end

	aes_key_sched u_key_sched (
		.clk(clk),
		.arst_n(arst_n),
		.start(exp_start),
		.key({key0_q, key1_q, key2_q, key3_q}),
		.key_size(key_size_q),
		.done(exp_done),
		.wr(key_wr)
	);

	aes_ram #(
		.Width(128),
		.Depth(RowCount)
	) u_key_ram (
		.clk(clk),
		.we(key_wr.en),
		.waddr(key_wr.addr),
		.wdata(key_wr.data),
		.raddr(raddr),
		.rdata(round_key)
	);

	aes_round u_round (
		.state(data_q),
		.round_key(round_key),
		.inv(decrypt_q),
		.first(first_step),
		.last(last_step),
		.next_state(round_out)
	);

	`AES_ASSERT_NEXT(a_expand_when_stale, in_beat && !sched_ready_q, state_q == ST_EXPAND, "stale schedule not expanded")
	`AES_ASSERT_NEXT(a_ready_after_expand, state_q == ST_EXPAND && exp_done && !cfg_wr, sched_ready_q, "schedule not marked ready")
	`AES_ASSERT_IMPL(a_step_in_range, state_q == ST_ROUND, step_q <= nr, "round step beyond last round")
	`AES_ASSERT_NEXT(a_result_held, out_valid_q && out_stall, out_valid_q, "stalled result dropped")
endmodule
`default_nettype wire

// ----- verif/tb_aes_block_cipher_unit.sv -----
// testbench of the aes block cipher unit: a self-checking run against a built-in cipher model
module tb_aes_block_cipher_unit;
	import aes_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 100;

	// block bytes in order, byte 0 in the top bits of the 128-bit vector
	typedef logic [0:15][7:0] blk_t;
	typedef struct {
		logic [63:0] high;
		logic [63:0] low;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [63:0] block_high = '0;
	logic [63:0] block_low = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] result_high;
	logic [63:0] result_low;

	aes_block_cipher_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.block_high(block_high),
		.block_low(block_low),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_high(result_high),
		.result_low(result_low)
	);

	// model copy of the registers and the round-key store
	logic [63:0] key_word_pair [4];
	logic [1:0] key_len_sel;
	logic inverse_sel;
	logic [31:0] round_key_store [60];
	logic schedule_valid;
	logic [7:0] fwd_box [256];
	logic [7:0] inv_box [256];

	result_t cipher_results [$];
	int err_count = 0;
	int blocks_sent = 0;
	int blocks_checked = 0;
	int cycles = 0;
	int hold_left = 0;
	bit no_idle = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles with %0d results pending", cycles,
				cipher_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
		input logic [63:0] got_v);
		err_count++;
		$display("mismatch %s: expected %h got %h (result %0d)", what, exp_v, got_v,
			blocks_checked);
	endtask

	// gf(2^8) arithmetic for the cipher model
	function automatic logic [7:0] gf_double(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = gf_double(a);
		end
		return acc;
	endfunction

	// substitution tables from the field inverse and the affine map
	task automatic build_boxes();
		logic [7:0] inv_v;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			inv_v = 8'h00;
			for (int y = 1; y < 256; y++) begin
				if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv_v = y[7:0];
			end
			s = inv_v ^ {inv_v[6:0], inv_v[7]} ^ {inv_v[5:0], inv_v[7:6]}
				^ {inv_v[4:0], inv_v[7:5]} ^ {inv_v[3:0], inv_v[7:4]} ^ 8'h63;
			fwd_box[x] = s;
			inv_box[s] = x[7:0];
		end
	endtask

	function automatic int key_word_count();
		return key_len_sel == KEY_SIZE_128 ? 4 : (key_len_sel == KEY_SIZE_192 ? 6 : 8);
	endfunction

	function automatic logic [31:0] sub_word_model(input logic [31:0] w);
		return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
	endfunction

	task automatic expand_schedule();
		int nk;
		logic [31:0] t;
		logic [7:0] rcon;
		nk = key_word_count();
		rcon = 8'h01;
		for (int i = 0; i < nk; i++) begin
			round_key_store[i] = i[0] ? key_word_pair[i >> 1][31:0]
				: key_word_pair[i >> 1][63:32];
		end
		for (int i = nk; i < 4 * (nk + 7); i++) begin
			t = round_key_store[i - 1];
			if (i % nk == 0) begin
				t = sub_word_model({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
				rcon = gf_double(rcon);
			end else if (nk > 6 && i % nk == 4) begin
				t = sub_word_model(t);
			end
			round_key_store[i] = round_key_store[i - nk] ^ t;
		end
		schedule_valid = 1'b1;
	endtask

	function automatic blk_t add_key(input blk_t s, input int rnd);
		logic [31:0] w;
		for (int c = 0; c < 4; c++) begin
			w = round_key_store[(rnd * 4 + c) % 60];
			for (int k = 0; k < 4; k++) s[4 * c + k] ^= w[31 - 8 * k -: 8];
		end
		return s;
	endfunction

	function automatic blk_t sub_all(input blk_t s, input bit inv);
		for (int n = 0; n < 16; n++) s[n] = inv ? inv_box[s[n]] : fwd_box[s[n]];
		return s;
	endfunction

	function automatic blk_t rotate_rows(input blk_t s, input bit inv);
		blk_t t;
		t = s;
		for (int r = 1; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inv) s[r + 4 * ((c + r) & 3)] = t[r + 4 * c];
				else s[r + 4 * c] = t[r + 4 * ((c + r) & 3)];
			end
		end
		return s;
	endfunction

	function automatic blk_t mix_all(input blk_t s, input bit inv);
		logic [7:0] coef [4];
		blk_t t;
		logic [7:0] v;
		if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
		else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
		t = s;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				v = '0;
				for (int k = 0; k < 4; k++) v ^= gf_mul(t[4 * c + k], coef[(k + 4 - r) & 3]);
				s[4 * c + r] = v;
			end
		end
		return s;
	endfunction

	function automatic blk_t cipher_block(input blk_t s);
		int nr;
		nr = key_word_count() + 6;
		if (!inverse_sel) begin
			s = add_key(s, 0);
			for (int r = 1; r < nr; r++) begin
				s = add_key(mix_all(rotate_rows(sub_all(s, 0), 0), 0), r);
			end
			s = add_key(rotate_rows(sub_all(s, 0), 0), nr);
		end else begin
			s = add_key(s, nr);
			for (int r = nr - 1; r > 0; r--) begin
				s = mix_all(add_key(sub_all(rotate_rows(s, 1), 1), r), 1);
			end
			s = add_key(sub_all(rotate_rows(s, 1), 1), 0);
		end
		return s;
	endfunction

	task automatic predict_result(input logic [63:0] hi, input logic [63:0] lo);
		blk_t s;
		result_t res;
		if (!schedule_valid) expand_schedule();
		s = cipher_block({hi, lo});
		res.high = s[0:7];
		res.low = s[8:15];
		cipher_results.push_back(res);
	endtask

	// register write over the apb port, mirrored into the model
	task automatic write_reg(input int idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(8 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
				key_word_pair[idx] = value;
				schedule_valid = 1'b0;
			end
			REG_KEY_SIZE: begin
				key_len_sel = value[1:0];
				schedule_valid = 1'b0;
			end
			REG_MODE: inverse_sel = value[0];
			default: ;
		endcase
	endtask

	// one input beat; returns on the edge that takes it
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		int gap;
		bit taken;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		block_high <= hi;
		block_low <= lo;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		predict_result(hi, lo);
		blocks_sent++;
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++) send_block({$urandom, $urandom}, {$urandom, $urandom});
	endtask

	// lower valid, let every result come out, then let the core settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (cipher_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic load_key(input logic [1:0] sz, input logic [63:0] k0, input logic [63:0] k1,
		input logic [63:0] k2, input logic [63:0] k3);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_KEY_SIZE, {62'h0, sz});
	endtask

	// output side: random stall before each beat, long hold-off on request
	always begin
		bit take;
		logic [63:0] got_hi;
		logic [63:0] got_lo;
		int stall_left;
		result_t want;
		stall_left = 0;
		forever begin
			@(negedge clk);
			take = out_valid && !out_stall;
			got_hi = result_high;
			got_lo = result_low;
			@(posedge clk);
			if (take) begin
				if (cipher_results.size() == 0) begin
					err_count++;
					$display("unexpected result %h %h", got_hi, got_lo);
				end else begin
					want = cipher_results.pop_front();
					if (got_hi !== want.high) report_mismatch("result_high", want.high, got_hi);
					if (got_lo !== want.low) report_mismatch("result_low", want.low, got_lo);
				end
				blocks_checked++;
				stall_left = no_idle ? 0 : $urandom_range(0, 5);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// reset values of the registers, zero key encrypts
	task automatic test_reset_defaults();
		send_block('0, '0);
		send_block('1, '1);
		wait_idle();
	endtask

	// published example vectors for each key length, both directions for the 128- and 192-bit keys
	task automatic test_known_vectors();
		load_key(KEY_SIZE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0);
		write_reg(REG_MODE, 64'h0);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		if (cipher_results[0].high !== 64'h69c4e0d86a7b0430) begin
			err_count++;
			$display("model disagrees with the aes-128 example vector");
		end
		wait_idle();
		// mode change keeps the schedule
		write_reg(REG_MODE, 64'h1);
		send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		wait_idle();
		load_key(KEY_SIZE_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, '0);
		send_block(64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
		wait_idle();
		write_reg(REG_MODE, 64'h0);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		wait_idle();
		load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
			64'h1011121314151617, 64'h18191a1b1c1d1e1f);
		send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
		wait_idle();
	endtask

	// block and key extremes, size three taken as a 256-bit key, stray register writes
	task automatic test_extremes();
		for (int sz = 0; sz < 4; sz++) begin
			for (int md = 0; md < 2; md++) begin
				load_key(sz[1:0], '1, '1, '1, '1);
				write_reg(REG_MODE, 64'(md));
				send_block('0, '0);
				send_block('1, '1);
				send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
				wait_idle();
			end
		end
		load_key(2'd3, '0, '0, '0, '0);
		write_reg(6, '1);
		write_reg(7, {$urandom, $urandom});
		send_block(64'h8000000000000000, 64'h0000000000000001);
		wait_idle();
	endtask

	// receiver holds off long enough for the core to fill and stall its input
	task automatic test_backpressure();
		hold_left = 400;
		no_idle = 1'b1;
		send_random(12);
		no_idle = 1'b0;
		wait_idle();
	endtask

	// random keys, sizes and modes, each phase drained before the next setting
	task automatic test_random_phases();
		for (int ph = 0; ph < 20; ph++) begin
			if ($urandom_range(0, 3) != 0) begin
				load_key(2'($urandom_range(0, 3)), {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			end
			write_reg(REG_MODE, {$urandom, $urandom});
			no_idle = (ph % 5 == 3);
			send_random(25);
			no_idle = 1'b0;
			wait_idle();
		end
	endtask

	initial begin
		key_word_pair = '{default: '0};
		key_len_sel = '0;
		inverse_sel = 1'b0;
		round_key_store = '{default: '0};
		schedule_valid = 1'b0;
		build_boxes();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_known_vectors();
		test_extremes();
		test_backpressure();
		test_random_phases();
		$display("sent %0d blocks and checked %0d results", blocks_sent, blocks_checked);
		$display("covered all key sizes, both directions, stalls and a long output hold-off");
		if (err_count == 0 && cipher_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/aes_pkg.sv
hw/rtl/aes_ram.sv
hw/rtl/aes_key_sched.sv
hw/rtl/aes_round.sv
hw/rtl/aes_block_cipher_unit.sv
verif/tb_aes_block_cipher_unit.sv
